>>> rtl/htfd_pkg.sv
// Shared types and constants of the humidity/temperature frame decoder.
package htfd_pkg;

  // CRC-8, polynomial x^8+x^5+x^4+1, no reflection, no final xor
  localparam logic [7:0] CRC_POLY = 8'h31;
  localparam logic [7:0] CRC_INIT = 8'hFF;

  // Frame queue between byte front end and conversion back end
  localparam int FIFO_DEPTH = 2;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

  // Doubled scale factors and rounding bias: q = (raw*2*full + 65535) / (2*65535)
  localparam logic [15:0] TEMP_SCALE2 = 16'd35000;
  localparam logic [15:0] HUM_SCALE2  = 16'd20000;
  localparam logic [15:0] ROUND_BIAS  = 16'hFFFF;
  localparam logic [15:0] FULL_SCALE  = 16'hFFFF;

  localparam logic [14:0] TEMP_OFFSET   = 15'd4500;
  localparam logic [14:0] FALLBACK_TEMP = 15'd10000;
  localparam logic [13:0] FALLBACK_HUM  = 14'd0;
  localparam logic [13:0] HUM_MAX       = 14'd10000;
  localparam logic [14:0] TEMP_MAX      = 15'd13000;

  // Byte position within one sensor reply
  typedef enum logic [2:0] {
    POS_T_MSB = 3'd0,
    POS_T_LSB = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_MSB = 3'd3,
    POS_H_LSB = 3'd4,
    POS_H_CRC = 3'd5
  } pos_t;

  // One complete reply, as handed from front end to back end
  typedef struct packed {
    logic [15:0] raw_temp;
    logic [15:0] raw_hum;
    logic        temp_ok;
    logic        hum_ok;
    logic        replace_bad;
  } frame_t;

endpackage

>>> rtl/htfd_front.sv
// Front end: byte sequencing, CRC-8 checks and raw word assembly.
module htfd_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [7:0]        s_axis_tdata,   // [7:0] byte_value
  input  logic [0:0]        s_axis_tuser,   // [0] frame_start
  input  logic              cfg_we,
  input  logic              cfg_wdata,
  input  logic              fifo_full,
  output logic              push,
  output htfd_pkg::frame_t  push_data
);

  htfd_pkg::pos_t byte_position;
  htfd_pkg::pos_t eff_pos;
  logic [7:0]     running_crc;
  logic [15:0]    raw_temperature;
  logic [15:0]    raw_humidity;
  logic           temp_check_passed;
  logic           replace_bad;
  logic [7:0]     crc_base;
  logic [7:0]     crc_calc;
  logic           accept;
  logic           crc_match;

  // Bytewise CRC-8 update, eight shift steps
  function automatic logic [7:0] crc8(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ htfd_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  assign s_axis_tready = !fifo_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // Frame start (or an impossible position) restarts the reply
  always_comb begin
    if (s_axis_tuser[0] || (byte_position > htfd_pkg::POS_H_CRC)) begin
      eff_pos = htfd_pkg::POS_T_MSB;
    end else begin
      eff_pos = byte_position;
    end
    if ((eff_pos == htfd_pkg::POS_T_MSB) || (eff_pos == htfd_pkg::POS_H_MSB)) begin
      crc_base = htfd_pkg::CRC_INIT;
    end else begin
      crc_base = running_crc;
    end
    crc_calc  = crc8(crc_base, s_axis_tdata);
    crc_match = (running_crc == s_axis_tdata);
  end

  // Sixth byte hands the whole reply to the queue
  assign push = accept && (eff_pos == htfd_pkg::POS_H_CRC);
  always_comb begin
    push_data.raw_temp    = raw_temperature;
    push_data.raw_hum     = raw_humidity;
    push_data.temp_ok     = temp_check_passed;
    push_data.hum_ok      = crc_match;
    push_data.replace_bad = replace_bad;
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      replace_bad <= 1'b1;
    end else if (cfg_we) begin
      replace_bad <= cfg_wdata;
    end
  end

  // Position and CRC state
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= htfd_pkg::POS_T_MSB;
      running_crc       <= htfd_pkg::CRC_INIT;
      temp_check_passed <= 1'b0;
    end else if (accept) begin
      case (eff_pos)
        htfd_pkg::POS_T_MSB, htfd_pkg::POS_T_LSB,
        htfd_pkg::POS_H_MSB, htfd_pkg::POS_H_LSB: begin
          running_crc <= crc_calc;
        end
        htfd_pkg::POS_T_CRC: begin
          temp_check_passed <= crc_match;
          running_crc       <= htfd_pkg::CRC_INIT;
        end
        default: begin
          running_crc <= htfd_pkg::CRC_INIT;
        end
      endcase
      if (eff_pos == htfd_pkg::POS_H_CRC) begin
        byte_position <= htfd_pkg::POS_T_MSB;
      end else begin
        byte_position <= htfd_pkg::pos_t'(eff_pos + 3'd1);
      end
    end
  end

  // Raw word assembly, MSB first
  always_ff @(posedge clk) begin
    if (accept) begin
      case (eff_pos)
        htfd_pkg::POS_T_MSB: raw_temperature[15:8] <= s_axis_tdata;
        htfd_pkg::POS_T_LSB: raw_temperature[7:0]  <= s_axis_tdata;
        htfd_pkg::POS_H_MSB: raw_humidity[15:8]    <= s_axis_tdata;
        htfd_pkg::POS_H_LSB: raw_humidity[7:0]     <= s_axis_tdata;
        default: begin
        end
      endcase
    end
  end

endmodule

>>> rtl/htfd_fifo.sv
// Short frame queue between the front end and the conversion back end.
module htfd_fifo (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  htfd_pkg::frame_t  din,
  input  logic              pop,
  output htfd_pkg::frame_t  dout,
  output logic              full,
  output logic              empty
);

  htfd_pkg::frame_t                entries [htfd_pkg::FIFO_DEPTH];
  logic [htfd_pkg::FIFO_AW-1:0]    wr_ptr;
  logic [htfd_pkg::FIFO_AW-1:0]    rd_ptr;
  logic [htfd_pkg::FIFO_AW:0]      count;
  logic                            do_push;
  logic                            do_pop;

  localparam logic [htfd_pkg::FIFO_AW-1:0] LAST_PTR = htfd_pkg::FIFO_AW'(htfd_pkg::FIFO_DEPTH - 1);
  localparam logic [htfd_pkg::FIFO_AW:0]   DEPTH_CNT = (htfd_pkg::FIFO_AW + 1)'(htfd_pkg::FIFO_DEPTH);

  assign full    = (count == DEPTH_CNT);
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = entries[rd_ptr];

  // Entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= din;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst) count <= DEPTH_CNT)
    else $error("frame queue count exceeds depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("frame pushed into full queue");

endmodule

>>> rtl/htfd_back.sv
// Back end: scaling pipeline, fallback selection and output register.
module htfd_back (
  input  logic              clk,
  input  logic              rst,
  input  htfd_pkg::frame_t  fifo_dout,
  input  logic              fifo_empty,
  output logic              pop,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [14:0]       temperature_centi,
  output logic [13:0]       humidity_centi,
  output logic              temp_crc_ok,
  output logic              hum_crc_ok
);

  logic        adv;
  // stage 1: scaled numerators
  logic        s1_valid;
  logic [31:0] s1_num_t;
  logic [31:0] s1_num_h;
  logic        s1_tok;
  logic        s1_hok;
  logic        s1_rb;
  // stage 2: halved numerators and quotient estimates
  logic        s2_valid;
  logic [30:0] s2_y_t;
  logic [30:0] s2_y_h;
  logic [15:0] s2_q_t;
  logic [15:0] s2_q_h;
  logic        s2_tok;
  logic        s2_hok;
  logic        s2_rb;
  // combinational
  logic [31:0] num_t;
  logic [31:0] num_h;
  logic [15:0] est_t;
  logic [15:0] est_h;
  logic [31:0] rem_t;
  logic [31:0] rem_h;
  logic [15:0] q_t;
  logic [15:0] q_h;
  logic [14:0] temp_next;
  logic [13:0] hum_next;

  // y/65535 estimate: (y + y/65536)/65536, low by at most one
  function automatic logic [15:0] quot_est(input logic [30:0] y);
    logic [31:0] s;
    s = {1'b0, y} + {17'b0, y[30:16]};
    return s[31:16];
  endfunction

  // Remainder against the estimate; q*65535 as a shift and subtract
  function automatic logic [31:0] quot_rem(input logic [30:0] y, input logic [15:0] q);
    return {1'b0, y} - ({q, 16'b0} - {16'b0, q});
  endfunction

  // Whole pipeline moves together when the output slot frees up
  assign adv = !m_axis_tvalid || m_axis_tready;
  assign pop = adv && !fifo_empty;

  // Stage 1 multiply and rounding bias
  always_comb begin
    num_t = 32'(fifo_dout.raw_temp) * 32'(htfd_pkg::TEMP_SCALE2) + 32'(htfd_pkg::ROUND_BIAS);
    num_h = 32'(fifo_dout.raw_hum) * 32'(htfd_pkg::HUM_SCALE2) + 32'(htfd_pkg::ROUND_BIAS);
  end

  // Stage 2 estimate, stage 3 correction, offset and fallback selection
  always_comb begin
    est_t = quot_est(s1_num_t[31:1]);
    est_h = quot_est(s1_num_h[31:1]);
    rem_t = quot_rem(s2_y_t, s2_q_t);
    rem_h = quot_rem(s2_y_h, s2_q_h);
    q_t   = s2_q_t + 16'(rem_t >= 32'(htfd_pkg::FULL_SCALE));
    q_h   = s2_q_h + 16'(rem_h >= 32'(htfd_pkg::FULL_SCALE));
    if (s2_rb && !(s2_tok && s2_hok)) begin
      temp_next = htfd_pkg::FALLBACK_TEMP;
      hum_next  = htfd_pkg::FALLBACK_HUM;
    end else begin
      temp_next = q_t[14:0] - htfd_pkg::TEMP_OFFSET;
      hum_next  = q_h[13:0];
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      s2_valid      <= 1'b0;
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      s1_valid      <= pop;
      s2_valid      <= s1_valid;
      m_axis_tvalid <= s2_valid;
    end
  end

  // Payload stages
  always_ff @(posedge clk) begin
    if (adv) begin
      s1_num_t          <= num_t;
      s1_num_h          <= num_h;
      s1_tok            <= fifo_dout.temp_ok;
      s1_hok            <= fifo_dout.hum_ok;
      s1_rb             <= fifo_dout.replace_bad;
      s2_y_t            <= s1_num_t[31:1];
      s2_y_h            <= s1_num_h[31:1];
      s2_q_t            <= est_t;
      s2_q_h            <= est_h;
      s2_tok            <= s1_tok;
      s2_hok            <= s1_hok;
      s2_rb             <= s1_rb;
      temperature_centi <= temp_next;
      humidity_centi    <= hum_next;
      temp_crc_ok       <= s2_tok;
      hum_crc_ok        <= s2_hok;
    end
  end

  a_est_within_one: assert property (@(posedge clk) disable iff (rst)
    s2_valid |-> (rem_t < 32'd131070) && (rem_h < 32'd131070))
    else $error("quotient estimate off by more than one");
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> humidity_centi <= htfd_pkg::HUM_MAX)
    else $error("humidity result out of range");
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> ($signed(temperature_centi) <= $signed(htfd_pkg::TEMP_MAX))
                   && ($signed(temperature_centi) >= -$signed(htfd_pkg::TEMP_OFFSET)))
    else $error("temperature result out of range");

endmodule

>>> rtl/humidity_temp_frame_decoder.sv
// Top level of the humidity/temperature sensor reply decoder.
// Accepts one reply byte per clock (temperature MSB, LSB, CRC, then humidity
// MSB, LSB, CRC; tuser marks the first byte) and emits one result per reply
// after its sixth byte. A new byte can enter every cycle; the front end
// stalls input only when the two-entry frame queue is full, which happens
// only when the output is held off. The conversion pipeline (one multiply
// stage, one quotient-estimate stage, one correction stage) takes one frame
// per cycle while the output is not held off. replace_bad resets to 1 and
// should be written only while no reply is in flight.
module humidity_temp_frame_decoder (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] byte_value
  input  logic [0:0]  s_axis_tuser,   // [0] frame_start
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [14:0] temperature_centi, [28:15] humidity_centi, zeros
  output logic [1:0]  m_axis_tuser,   // [0] temp_crc_ok, [1] hum_crc_ok
  input  logic        cfg_we,
  input  logic        cfg_wdata       // replace_bad
);

  htfd_pkg::frame_t push_data;
  htfd_pkg::frame_t fifo_dout;
  logic             push;
  logic             pop;
  logic             fifo_full;
  logic             fifo_empty;
  logic [14:0]      temperature_centi;
  logic [13:0]      humidity_centi;
  logic             temp_crc_ok;
  logic             hum_crc_ok;

  htfd_front u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fifo_full     (fifo_full),
    .push          (push),
    .push_data     (push_data)
  );

  htfd_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (push),
    .din   (push_data),
    .pop   (pop),
    .dout  (fifo_dout),
    .full  (fifo_full),
    .empty (fifo_empty)
  );

  htfd_back u_back (
    .clk               (clk),
    .rst               (rst),
    .fifo_dout         (fifo_dout),
    .fifo_empty        (fifo_empty),
    .pop               (pop),
    .m_axis_tvalid     (m_axis_tvalid),
    .m_axis_tready     (m_axis_tready),
    .temperature_centi (temperature_centi),
    .humidity_centi    (humidity_centi),
    .temp_crc_ok       (temp_crc_ok),
    .hum_crc_ok        (hum_crc_ok)
  );

  // Result packing
  assign m_axis_tdata = {3'b000, humidity_centi, temperature_centi};
  assign m_axis_tuser = {hum_crc_ok, temp_crc_ok};

endmodule
